FILE: sv/lamport_request_queue_defines.svh
// Assertion helpers for the checker of the request queue.
`ifndef LAMPORT_REQUEST_QUEUE_DEFINES_SVH
`define LAMPORT_REQUEST_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("lamport_request_queue: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("lamport_request_queue: assertion failed");

`endif

FILE: sv/lrq_pkg.sv
`default_nettype none

package lrq_pkg;

    localparam int KIND_BITS      = 3;
    localparam int SENDER_BITS    = 4;
    localparam int IN_STAMP_BITS  = 32;
    localparam int OUT_STAMP_BITS = 32;
    localparam int RANK_BITS      = 4;
    localparam int COUNT_BITS     = 5;
    localparam int CFG_IDX_BITS   = 4;
    localparam int CFG_DATA_BITS  = 5;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_REM_REQ = 3'd0,
        KIND_REM_REL = 3'd1,
        KIND_ACK     = 3'd2,
        KIND_LOC_REQ = 3'd3,
        KIND_LOC_REL = 3'd4
    } t_kind;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_OWN_RANK        = 4'd0,
        CFG_PROCESS_COUNT   = 4'd1,
        CFG_EQUIPMENT_SLOTS = 4'd2,
        CFG_LAB_SLOTS       = 4'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [RANK_BITS-1:0]  own_rank;
        logic [COUNT_BITS-1:0] process_count;
        logic [COUNT_BITS-1:0] equipment_slots;
        logic [COUNT_BITS-1:0] lab_slots;
    } t_cfg;

    // Per-item outcome of the clock and table update.
    typedef struct packed {
        logic [OUT_STAMP_BITS-1:0] clock_now;
        logic                      ack_out;
        logic [OUT_STAMP_BITS-1:0] ack_stamp_out;
    } t_step;

endpackage

`default_nettype wire

FILE: sv/lrq_if.sv
`default_nettype none

interface lrq_in_if import lrq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [KIND_BITS-1:0]     kind;
    logic                     resource;
    logic [SENDER_BITS-1:0]   sender;
    logic [IN_STAMP_BITS-1:0] stamp;

    modport source (output valid, kind, resource, sender, stamp, input ready);
    modport sink   (input valid, kind, resource, sender, stamp, output ready);
endinterface

interface lrq_out_if import lrq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [OUT_STAMP_BITS-1:0] clock_now;
    logic                      ack_out;
    logic [OUT_STAMP_BITS-1:0] ack_stamp_out;
    logic                      equipment_granted;
    logic                      lab_granted;
    logic                      acks_complete;

    modport source (output valid, clock_now, ack_out, ack_stamp_out, equipment_granted,
                    lab_granted, acks_complete, input ready);
    modport sink   (input valid, clock_now, ack_out, ack_stamp_out, equipment_granted,
                    lab_granted, acks_complete, output ready);
endinterface

interface lrq_cfg_if import lrq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/lrq_table.sv
`default_nettype none

module lrq_table import lrq_pkg::*; #(
    parameter int MAX_PROCS  = 16,
    parameter int STAMP_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_apply,
    input  logic [KIND_BITS-1:0]     i_kind,
    input  logic                     i_resource,
    input  logic [SENDER_BITS-1:0]   i_sender,
    input  logic [IN_STAMP_BITS-1:0] i_stamp,
    input  logic [RANK_BITS-1:0]     i_own_rank,
    output t_step                    o_step,
    output logic [MAX_PROCS-1:0]     o_eq_valid,
    output logic [STAMP_BITS-1:0]    o_eq_stamp [MAX_PROCS],
    output logic [MAX_PROCS-1:0]     o_lab_valid,
    output logic [STAMP_BITS-1:0]    o_lab_stamp [MAX_PROCS],
    output logic [MAX_PROCS-1:0]     o_ack_seen,
    output logic [STAMP_BITS-1:0]    o_ack_stamp [MAX_PROCS],
    output logic [STAMP_BITS-1:0]    o_pending_stamp
);

    localparam int IW = ($clog2(MAX_PROCS) > SENDER_BITS) ? $clog2(MAX_PROCS) : SENDER_BITS;
    localparam int CB = IW + 1;

    logic [STAMP_BITS-1:0] r_clock;
    logic [STAMP_BITS-1:0] n_clock;
    logic [STAMP_BITS-1:0] r_pending;
    logic [STAMP_BITS-1:0] w_stamp;
    logic [STAMP_BITS-1:0] w_max;
    logic [STAMP_BITS-1:0] w_ack_stamp;
    logic                  w_ack;

    assign w_stamp = STAMP_BITS'(i_stamp);
    assign w_max   = (r_clock > w_stamp) ? r_clock : w_stamp;

    always_comb begin
        n_clock     = r_clock;
        w_ack       = 1'b0;
        w_ack_stamp = '0;
        case (i_kind) inside
            KIND_REM_REQ: begin
                // receive bump, then the bump for the ack that goes out
                n_clock     = w_max + STAMP_BITS'(2);
                w_ack       = 1'b1;
                w_ack_stamp = w_max + STAMP_BITS'(2);
            end
            KIND_REM_REL, KIND_ACK: begin
                n_clock = w_max + STAMP_BITS'(1);
            end
            KIND_LOC_REL: begin
                n_clock = r_clock + STAMP_BITS'(1);
            end
            default: begin
                n_clock = r_clock;
            end
        endcase
    end

    assign o_step.clock_now     = OUT_STAMP_BITS'(n_clock);
    assign o_step.ack_out       = w_ack;
    assign o_step.ack_stamp_out = OUT_STAMP_BITS'(w_ack_stamp);
    assign o_pending_stamp      = r_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock   <= '0;
            r_pending <= '0;
        end else if (i_apply) begin
            r_clock <= n_clock;
            if (i_kind == KIND_LOC_REQ) begin
                r_pending <= r_clock;
            end
        end
    end

    for (genvar r = 0; r < 2; r++) begin : g_res
        for (genvar p = 0; p < MAX_PROCS; p++) begin : g_entry
            localparam bit RES = (r != 0);
            logic                  w_sel_rem;
            logic                  w_sel_own;
            logic                  r_v;
            logic [STAMP_BITS-1:0] r_s;

            assign w_sel_rem = (i_resource == RES) && (CB'(i_sender) == CB'(p));
            assign w_sel_own = (i_resource == RES) && (CB'(i_own_rank) == CB'(p));

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v <= 1'b0;
                end else if (i_apply) begin
                    if ((i_kind == KIND_REM_REQ && w_sel_rem) ||
                        (i_kind == KIND_LOC_REQ && w_sel_own)) begin
                        r_v <= 1'b1;
                    end else if ((i_kind == KIND_REM_REL && w_sel_rem) ||
                                 (i_kind == KIND_LOC_REL && w_sel_own)) begin
                        r_v <= 1'b0;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_apply) begin
                    if (i_kind == KIND_REM_REQ && w_sel_rem) begin
                        r_s <= w_stamp;
                    end else if (i_kind == KIND_LOC_REQ && w_sel_own) begin
                        r_s <= r_clock;
                    end
                end
            end

            if (r == 0) begin : g_eq
                assign o_eq_valid[p] = r_v;
                assign o_eq_stamp[p] = r_s;
            end else begin : g_lab
                assign o_lab_valid[p] = r_v;
                assign o_lab_stamp[p] = r_s;
            end
        end
    end

    for (genvar p = 0; p < MAX_PROCS; p++) begin : g_ack
        logic                  w_sel;
        logic                  r_seen;
        logic [STAMP_BITS-1:0] r_astamp;

        assign w_sel = i_apply && (i_kind == KIND_ACK) && (CB'(i_sender) == CB'(p));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_seen <= 1'b0;
            end else if (w_sel) begin
                r_seen <= 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_sel) begin
                r_astamp <= w_stamp;
            end
        end

        assign o_ack_seen[p]  = r_seen;
        assign o_ack_stamp[p] = r_astamp;
    end

endmodule

`default_nettype wire

FILE: sv/lrq_grant.sv
`default_nettype none

module lrq_grant import lrq_pkg::*; #(
    parameter int MAX_PROCS  = 16,
    parameter int STAMP_BITS = 32
) (
    input  logic [MAX_PROCS-1:0]  i_valid,
    input  logic [STAMP_BITS-1:0] i_stamp [MAX_PROCS],
    input  logic [RANK_BITS-1:0]  i_own_rank,
    input  logic [COUNT_BITS-1:0] i_slots,
    output logic                  o_granted
);

    localparam int IW = ($clog2(MAX_PROCS) > RANK_BITS) ? $clog2(MAX_PROCS) : RANK_BITS;
    localparam int CB = IW + 1;
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int GW = ((CW > COUNT_BITS) ? CW : COUNT_BITS) + 1;

    logic [MAX_PROCS-1:0]  w_own_hit;
    logic [MAX_PROCS-1:0]  w_ahead;
    logic [STAMP_BITS-1:0] w_own_stamp;
    logic                  w_own_valid;
    logic [CW-1:0]         w_count;

    for (genvar p = 0; p < MAX_PROCS; p++) begin : g_hit
        assign w_own_hit[p] = (CB'(i_own_rank) == CB'(p));
    end

    assign w_own_valid = |(w_own_hit & i_valid);

    always_comb begin
        w_own_stamp = '0;
        for (int p = 0; p < MAX_PROCS; p++) begin
            if (w_own_hit[p]) begin
                w_own_stamp = w_own_stamp | i_stamp[p];
            end
        end
    end

    // entries ordered by (stamp, rank): ties go to the lower rank
    for (genvar p = 0; p < MAX_PROCS; p++) begin : g_rank
        assign w_ahead[p] = i_valid[p] && !w_own_hit[p] &&
                            ((i_stamp[p] < w_own_stamp) ||
                             (i_stamp[p] == w_own_stamp && CB'(p) < CB'(i_own_rank)));
    end

    assign w_count   = CW'($countones(w_ahead));
    assign o_granted = w_own_valid && (GW'(w_count) < GW'(i_slots));

endmodule

`default_nettype wire

FILE: sv/lrq_acks.sv
`default_nettype none

module lrq_acks import lrq_pkg::*; #(
    parameter int MAX_PROCS  = 16,
    parameter int STAMP_BITS = 32
) (
    input  logic [MAX_PROCS-1:0]  i_seen,
    input  logic [STAMP_BITS-1:0] i_stamp [MAX_PROCS],
    input  logic [STAMP_BITS-1:0] i_pending,
    input  logic [RANK_BITS-1:0]  i_own_rank,
    input  logic [COUNT_BITS-1:0] i_process_count,
    output logic                  o_complete
);

    localparam int IW = ($clog2(MAX_PROCS) > COUNT_BITS) ? $clog2(MAX_PROCS) : COUNT_BITS;
    localparam int CB = IW + 1;

    logic [MAX_PROCS-1:0] w_missing;

    for (genvar p = 0; p < MAX_PROCS; p++) begin : g_proc
        logic w_skip;
        assign w_skip = (CB'(p) >= CB'(i_process_count)) || (CB'(p) == CB'(i_own_rank));
        assign w_missing[p] = !w_skip && (!i_seen[p] || (i_stamp[p] < i_pending));
    end

    assign o_complete = ~|w_missing;

endmodule

`default_nettype wire

FILE: sv/lamport_request_queue.sv
// Lamport request queue for two counted resources (equipment, laboratory). Each input beat is
// a remote request, remote release, ack, local request or local release; the block updates its
// logical clock and request table in the cycle the beat is accepted and returns one result beat
// with the new clock, the ack to send, both grant flags and the all-acks flag. One beat is taken
// per cycle when not stalled; a result passes the stage-1 and output registers. The table
// update is one pass over the register table; grant and ack checks run as the staged result
// moves on, as 2*MAX_PROCS parallel stamp comparators plus MAX_PROCS ack comparators into the
// output register. Input ready drops only in reset or while a staged result and the output
// register are both held by the sink. Configuration is written at any time through its own
// channel and is ready whenever reset is released; it must only change while the block is idle.
`default_nettype none

module lamport_request_queue import lrq_pkg::*; #(
    parameter int MAX_PROCS  = 16,
    parameter int STAMP_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lrq_cfg_if.sink   i_cfg,
    lrq_in_if.sink    i_in,
    lrq_out_if.source o_out
);

    t_cfg  r_cfg;
    t_step w_step;
    t_step r_s1_step;
    t_step r_out_step;
    logic  r_s1_valid;
    logic  n_s1_valid;
    logic  r_out_valid;
    logic  n_out_valid;
    logic  r_out_eq;
    logic  r_out_lab;
    logic  r_out_acks;
    logic  w_accept;
    logic  w_s1_move;
    logic  w_eq_granted;
    logic  w_lab_granted;
    logic  w_acks_complete;

    logic [MAX_PROCS-1:0]  w_eq_valid;
    logic [STAMP_BITS-1:0] w_eq_stamp [MAX_PROCS];
    logic [MAX_PROCS-1:0]  w_lab_valid;
    logic [STAMP_BITS-1:0] w_lab_stamp [MAX_PROCS];
    logic [MAX_PROCS-1:0]  w_ack_seen;
    logic [STAMP_BITS-1:0] w_ack_stamp [MAX_PROCS];
    logic [STAMP_BITS-1:0] w_pending;

    // configuration registers
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_rank        <= '0;
            r_cfg.process_count   <= COUNT_BITS'(16);
            r_cfg.equipment_slots <= COUNT_BITS'(2);
            r_cfg.lab_slots       <= COUNT_BITS'(2);
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_OWN_RANK:        r_cfg.own_rank        <= i_cfg.data[RANK_BITS-1:0];
                CFG_PROCESS_COUNT:   r_cfg.process_count   <= i_cfg.data;
                CFG_EQUIPMENT_SLOTS: r_cfg.equipment_slots <= i_cfg.data;
                CFG_LAB_SLOTS:       r_cfg.lab_slots       <= i_cfg.data;
                default:             r_cfg <= r_cfg;
            endcase
        end
    end

    // handshake: stage 1 holds the update outcome, stage 2 is the output register
    assign w_s1_move  = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = i_rst_n && (!r_s1_valid || w_s1_move);
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_accept) begin
            n_s1_valid = 1'b1;
        end else if (w_s1_move) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_s1_move) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_step <= w_step;
        end
        // the table already reflects the staged beat, so grants are taken from it now
        if (w_s1_move) begin
            r_out_step <= r_s1_step;
            r_out_eq   <= w_eq_granted;
            r_out_lab  <= w_lab_granted;
            r_out_acks <= w_acks_complete;
        end
    end

    lrq_table #(
        .MAX_PROCS  (MAX_PROCS),
        .STAMP_BITS (STAMP_BITS)
    ) u_table (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_apply         (w_accept),
        .i_kind          (i_in.kind),
        .i_resource      (i_in.resource),
        .i_sender        (i_in.sender),
        .i_stamp         (i_in.stamp),
        .i_own_rank      (r_cfg.own_rank),
        .o_step          (w_step),
        .o_eq_valid      (w_eq_valid),
        .o_eq_stamp      (w_eq_stamp),
        .o_lab_valid     (w_lab_valid),
        .o_lab_stamp     (w_lab_stamp),
        .o_ack_seen      (w_ack_seen),
        .o_ack_stamp     (w_ack_stamp),
        .o_pending_stamp (w_pending)
    );

    lrq_grant #(
        .MAX_PROCS  (MAX_PROCS),
        .STAMP_BITS (STAMP_BITS)
    ) u_grant_eq (
        .i_valid    (w_eq_valid),
        .i_stamp    (w_eq_stamp),
        .i_own_rank (r_cfg.own_rank),
        .i_slots    (r_cfg.equipment_slots),
        .o_granted  (w_eq_granted)
    );

    lrq_grant #(
        .MAX_PROCS  (MAX_PROCS),
        .STAMP_BITS (STAMP_BITS)
    ) u_grant_lab (
        .i_valid    (w_lab_valid),
        .i_stamp    (w_lab_stamp),
        .i_own_rank (r_cfg.own_rank),
        .i_slots    (r_cfg.lab_slots),
        .o_granted  (w_lab_granted)
    );

    lrq_acks #(
        .MAX_PROCS  (MAX_PROCS),
        .STAMP_BITS (STAMP_BITS)
    ) u_acks (
        .i_seen          (w_ack_seen),
        .i_stamp         (w_ack_stamp),
        .i_pending       (w_pending),
        .i_own_rank      (r_cfg.own_rank),
        .i_process_count (r_cfg.process_count),
        .o_complete      (w_acks_complete)
    );

    assign o_out.valid             = r_out_valid;
    assign o_out.clock_now         = r_out_step.clock_now;
    assign o_out.ack_out           = r_out_step.ack_out;
    assign o_out.ack_stamp_out     = r_out_step.ack_stamp_out;
    assign o_out.equipment_granted = r_out_eq;
    assign o_out.lab_granted       = r_out_lab;
    assign o_out.acks_complete     = r_out_acks;

endmodule

`default_nettype wire

FILE: sv/lrq_checker.sv
`default_nettype none
`include "lamport_request_queue_defines.svh"

module lrq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_clock,
    input logic        i_out_ack,
    input logic [31:0] i_out_ack_stamp,
    input logic        i_out_eq,
    input logic        i_out_lab,
    input logic        i_out_acks
);

    logic [67:0] w_payload;
    logic        w_in_beat;

    assign w_payload = {i_out_clock, i_out_ack, i_out_ack_stamp, i_out_eq, i_out_lab,
                        i_out_acks};
    assign w_in_beat = i_in_valid && i_in_ready;

    // a held result beat keeps its contents
    `LRQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(w_payload))

    // input backpressure only comes from a stalled sink
    `LRQ_ASSERT_IMP(a_ready_stall, i_clk, i_rst_n, !i_in_ready, i_out_valid && !i_out_ready)

    // every accepted beat is followed by a valid result once past the stage-1 and output registers
    `LRQ_ASSERT_IMP(a_in_to_out, i_clk, i_rst_n, w_in_beat, ##2 i_out_valid)

    // a result appearing on an idle output came from a beat that went straight through stage 1
    `LRQ_ASSERT_IMP(a_out_source, i_clk, i_rst_n, $rose(i_out_valid), $past(w_in_beat, 2))

endmodule

bind lamport_request_queue lrq_checker u_lrq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_clock     (o_out.clock_now),
    .i_out_ack       (o_out.ack_out),
    .i_out_ack_stamp (o_out.ack_stamp_out),
    .i_out_eq        (o_out.equipment_granted),
    .i_out_lab       (o_out.lab_granted),
    .i_out_acks      (o_out.acks_complete)
);

`default_nettype wire

FILE: dv/tb_lamport_request_queue.sv
`timescale 1ns / 1ps

module tb_lamport_request_queue;
    import lrq_pkg::*;

    localparam int NPROC           = 16;
    localparam int LATENCY         = 2;
    localparam int LIMIT_CYCLES    = 200000;
    localparam int REPORT_MAX      = 10;
    localparam int ITEMS_PER_PHASE = 100;

    localparam logic RES_EQUIP = 1'b0;
    localparam logic RES_LAB   = 1'b1;

    // kinds with no defined action
    localparam logic [KIND_BITS-1:0] KIND_SPARE_5 = 3'd5;
    localparam logic [KIND_BITS-1:0] KIND_SPARE_6 = 3'd6;
    localparam logic [KIND_BITS-1:0] KIND_SPARE_7 = 3'd7;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_IDX = 4'd9;

    typedef struct packed {
        logic [KIND_BITS-1:0]     kind;
        logic                     resource;
        logic [SENDER_BITS-1:0]   sender;
        logic [IN_STAMP_BITS-1:0] stamp;
    } t_msg;

    typedef struct packed {
        logic [OUT_STAMP_BITS-1:0] clock_now;
        logic                      ack_out;
        logic [OUT_STAMP_BITS-1:0] ack_stamp_out;
        logic                      equipment_granted;
        logic                      lab_granted;
        logic                      acks_complete;
    } t_outcome;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    lrq_cfg_if cfg_if ();
    lrq_in_if  in_if ();
    lrq_out_if out_if ();

    lamport_request_queue #(
        .MAX_PROCS  (NPROC),
        .STAMP_BITS (32)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // local copy of the registers and the request table
    logic [RANK_BITS-1:0]  cfg_rank;
    logic [COUNT_BITS-1:0] cfg_count;
    logic [COUNT_BITS-1:0] cfg_eq_slots;
    logic [COUNT_BITS-1:0] cfg_lab_slots;
    logic [31:0]           lclock;
    logic [31:0]           own_pending;
    logic                  queue_valid [2*NPROC];
    logic [31:0]           queue_stamp [2*NPROC];
    logic                  ack_heard [NPROC];
    logic [31:0]           ack_heard_stamp [NPROC];

    t_outcome outcome_q [$];

    int msgs_sent;
    int results_checked;
    int mismatches;
    int cycle_count = 0;
    int kind_seen [8];
    int eq_grants;
    int lab_grants;
    int full_acks;
    int src_idle_pct;
    int sink_stall_pct;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timed out after %0d cycles, %0d results outstanding",
                     cycle_count, outcome_q.size());
            $display("lamport_request_queue: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ---------------------------------------------------------------- prediction

    function automatic int peer_span();
        return (cfg_count == 0 || cfg_count > NPROC) ? NPROC : int'(cfg_count);
    endfunction

    function automatic logic holds_slot(input int res, input logic [COUNT_BITS-1:0] slots);
        int base;
        int me;
        int ahead;
        base  = res * NPROC;
        me    = int'(cfg_rank);
        ahead = 0;
        if (!queue_valid[base + me])
            return 1'b0;
        for (int p = 0; p < NPROC; p++) begin
            if (p != me && queue_valid[base + p] &&
                (queue_stamp[base + p] < queue_stamp[base + me] ||
                 (queue_stamp[base + p] == queue_stamp[base + me] && p < me)))
                ahead++;
        end
        return ahead < int'(slots);
    endfunction

    function automatic logic all_acks_in();
        for (int p = 0; p < NPROC; p++) begin
            if (p < int'(cfg_count) && p != int'(cfg_rank) &&
                (!ack_heard[p] || ack_heard_stamp[p] < own_pending))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_outcome lamport_update(input t_msg m);
        t_outcome o;
        int base;
        int own;
        int src;
        base = int'(m.resource) * NPROC;
        own  = int'(cfg_rank);
        src  = int'(m.sender);
        o    = '0;
        case (m.kind) inside
            KIND_REM_REQ, KIND_REM_REL, KIND_ACK: begin
                lclock = ((lclock > m.stamp) ? lclock : m.stamp) + 32'd1;
                if (m.kind == KIND_REM_REQ) begin
                    queue_valid[base + src] = 1'b1;
                    queue_stamp[base + src] = m.stamp;
                    lclock                  = lclock + 32'd1;
                    o.ack_out               = 1'b1;
                    o.ack_stamp_out         = lclock;
                end else if (m.kind == KIND_REM_REL) begin
                    queue_valid[base + src] = 1'b0;
                end else begin
                    ack_heard[src]       = 1'b1;
                    ack_heard_stamp[src] = m.stamp;
                end
            end
            KIND_LOC_REQ: begin
                // stamped with the current clock, which does not move
                own_pending             = lclock;
                queue_valid[base + own] = 1'b1;
                queue_stamp[base + own] = lclock;
            end
            KIND_LOC_REL: begin
                queue_valid[base + own] = 1'b0;
                lclock                  = lclock + 32'd1;
            end
            default: ;
        endcase
        o.clock_now         = lclock;
        o.equipment_granted = holds_slot(0, cfg_eq_slots);
        o.lab_granted       = holds_slot(1, cfg_lab_slots);
        o.acks_complete     = all_acks_in();
        return o;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_BITS-1:0] idx,
                                           input logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            CFG_OWN_RANK:        cfg_rank      = data[RANK_BITS-1:0];
            CFG_PROCESS_COUNT:   cfg_count     = data;
            CFG_EQUIPMENT_SLOTS: cfg_eq_slots  = data;
            CFG_LAB_SLOTS:       cfg_lab_slots = data;
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("result %0d: %s expected 0x%08h got 0x%08h",
                         results_checked, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_outcome want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (outcome_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result beat with nothing outstanding, clock 0x%08h",
                             out_if.clock_now);
            end else begin
                want = outcome_q.pop_front();
                compare_field("clock_now", want.clock_now, out_if.clock_now);
                compare_field("ack_out", 32'(want.ack_out), 32'(out_if.ack_out));
                compare_field("ack_stamp_out", want.ack_stamp_out, out_if.ack_stamp_out);
                compare_field("equipment_granted", 32'(want.equipment_granted),
                              32'(out_if.equipment_granted));
                compare_field("lab_granted", 32'(want.lab_granted),
                              32'(out_if.lab_granted));
                compare_field("acks_complete", 32'(want.acks_complete),
                              32'(out_if.acks_complete));
                eq_grants  += int'(want.equipment_granted);
                lab_grants += int'(want.lab_granted);
                full_acks  += int'(want.acks_complete);
            end
            results_checked++;
        end
    end

    // ---------------------------------------------------------------- driving

    // valid stays high after the beat; drain() or the next gap lowers it
    task automatic send_msg(input logic [KIND_BITS-1:0] kind, input logic res,
                            input logic [SENDER_BITS-1:0] sender, input logic [31:0] stamp);
        t_msg     m;
        t_outcome pred;
        m.kind     = kind;
        m.resource = res;
        m.sender   = sender;
        m.stamp    = stamp;
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.kind     <= kind;
        in_if.resource <= res;
        in_if.sender   <= sender;
        in_if.stamp    <= stamp;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        pred = lamport_update(m);
        outcome_q.insert(outcome_q.size(), pred);
        kind_seen[kind]++;
        msgs_sent++;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
        apply_register(idx, data);
    endtask

    task automatic set_config(input logic [4:0] rank, input logic [4:0] count,
                              input logic [4:0] eq_slots, input logic [4:0] lab_slots);
        cfg_write(CFG_OWN_RANK, rank);
        cfg_write(CFG_PROCESS_COUNT, count);
        cfg_write(CFG_EQUIPMENT_SLOTS, eq_slots);
        cfg_write(CFG_LAB_SLOTS, lab_slots);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_stamp();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return 32'hFFFF_FFFF - $urandom_range(3);
            default: return lclock - 32'd3 + $urandom_range(6);
        endcase
    endfunction

    function automatic logic [SENDER_BITS-1:0] pick_peer();
        if ($urandom_range(7) == 0)
            return SENDER_BITS'($urandom_range(NPROC - 1));
        return SENDER_BITS'($urandom_range(peer_span() - 1));
    endfunction

    // mostly fresh acks, now and then a stale one
    function automatic logic [31:0] ack_stamp_for();
        if ($urandom_range(5) == 0)
            return own_pending - 32'd1;
        return own_pending + $urandom_range(3);
    endfunction

    // local request, traffic from peers, optionally a full ack set, local release
    task automatic run_session();
        logic res;
        int   steps;
        int   span;
        res   = 1'($urandom_range(1));
        send_msg(KIND_LOC_REQ, res, SENDER_BITS'($urandom_range(15)), $urandom);
        steps = $urandom_range(2, 8);
        repeat (steps) begin
            case ($urandom_range(5)) inside
                0, 1:    send_msg(KIND_REM_REQ, 1'($urandom_range(1)), pick_peer(),
                                  pick_stamp());
                2:       send_msg(KIND_REM_REL, 1'($urandom_range(1)), pick_peer(),
                                  pick_stamp());
                3:       send_msg(KIND_LOC_REQ, !res, SENDER_BITS'($urandom_range(15)),
                                  $urandom);
                default: send_msg(KIND_ACK, res, pick_peer(), ack_stamp_for());
            endcase
        end
        span = peer_span();
        if ($urandom_range(1) == 1) begin
            for (int p = 0; p < span; p++)
                if (p != int'(cfg_rank))
                    send_msg(KIND_ACK, res, 4'(p), own_pending + $urandom_range(3));
        end
        send_msg(KIND_LOC_REL, res, SENDER_BITS'($urandom_range(15)), $urandom);
    endtask

    task automatic run_traffic(input int count);
        int stop_at;
        stop_at = msgs_sent + count;
        while (msgs_sent < stop_at) begin
            if ($urandom_range(9) < 7)
                run_session();
            else
                send_msg(KIND_BITS'($urandom_range(7)), 1'($urandom_range(1)),
                         SENDER_BITS'($urandom_range(15)), pick_stamp());
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed_reset_config();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_msg(KIND_ACK, RES_EQUIP, 4'd5, 32'd0);
        send_msg(KIND_REM_REQ, RES_EQUIP, 4'd3, 32'd10);
        send_msg(KIND_LOC_REQ, RES_EQUIP, 4'd15, 32'hFFFF_FFFF);   // sender, stamp ignored
        send_msg(KIND_REM_REQ, RES_EQUIP, 4'd1, 32'd5);            // own entry drops out
        send_msg(KIND_REM_REQ, RES_EQUIP, 4'd1, 32'd20);           // overwrite, back in
        send_msg(KIND_REM_REL, RES_LAB, 4'd9, 32'd0);              // nothing to remove
        send_msg(KIND_LOC_REQ, RES_LAB, 4'd0, 32'd0);
        send_msg(KIND_REM_REQ, RES_LAB, 4'd0, 32'd3);              // from own rank
        send_msg(KIND_SPARE_5, RES_LAB, 4'd10, 32'hAAAA_5555);
        send_msg(KIND_SPARE_6, RES_EQUIP, 4'd6, 32'h5555_AAAA);
        send_msg(KIND_SPARE_7, RES_LAB, 4'd15, 32'hFFFF_FFFF);
        send_msg(KIND_REM_REQ, RES_EQUIP, 4'd15, 32'hFFFF_FFFF);   // clock wraps
        send_msg(KIND_ACK, RES_LAB, 4'd15, 32'hFFFF_FFFE);
        send_msg(KIND_LOC_REL, RES_EQUIP, 4'd0, 32'd0);            // wraps again
        send_msg(KIND_LOC_REL, RES_LAB, 4'd7, 32'd1);
        drain();
    endtask

    task automatic test_directed_register_extremes();
        cfg_write(CFG_SPARE_IDX, 5'd31);
        set_config(5'd15, 5'd2, 5'd0, 5'd31);                      // no equipment slot
        send_msg(KIND_LOC_REQ, RES_EQUIP, 4'd2, 32'd7);
        send_msg(KIND_LOC_REQ, RES_LAB, 4'd2, 32'd7);
        send_msg(KIND_ACK, RES_EQUIP, 4'd0, 32'd100);
        send_msg(KIND_ACK, RES_LAB, 4'd1, 32'd100);
        drain();
        set_config(5'd3, 5'd0, 5'd16, 5'd1);                       // nobody to wait for
        send_msg(KIND_REM_REL, RES_EQUIP, 4'd7, 32'd0);
        drain();
        set_config(5'd1, 5'd31, 5'd1, 5'd16);
        send_msg(KIND_LOC_REQ, RES_EQUIP, 4'd8, 32'd0);
        send_msg(KIND_REM_REQ, RES_EQUIP, 4'd0, 32'd0);
        send_msg(KIND_ACK, RES_EQUIP, 4'd0, 32'hFFFF_FFFF);
        drain();
    endtask

    task automatic test_random_phases();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        set_config(5'd15, 5'd16, 5'd16, 5'd16);
        run_traffic(ITEMS_PER_PHASE);
        drain();

        src_idle_pct   = 71;
        sink_stall_pct = 0;
        set_config(5'($urandom_range(31)), 5'($urandom_range(1, 6)),
                   5'($urandom_range(1, 4)), 5'($urandom_range(1, 4)));
        run_traffic(ITEMS_PER_PHASE);
        drain();

        src_idle_pct   = 0;
        sink_stall_pct = 71;
        set_config(5'd0, 5'd1, 5'd1, 5'd1);
        run_traffic(ITEMS_PER_PHASE);
        drain();

        src_idle_pct   = 10;
        sink_stall_pct = 10;
        set_config(5'($urandom_range(31)), 5'($urandom_range(1, 6)),
                   5'($urandom_range(1, 4)), 5'($urandom_range(1, 4)));
        run_traffic(ITEMS_PER_PHASE);
        drain();
    endtask

    initial begin
        cfg_rank      = 4'd0;
        cfg_count     = 5'd16;
        cfg_eq_slots  = 5'd2;
        cfg_lab_slots = 5'd2;
        lclock        = '0;
        own_pending   = '0;
        for (int i = 0; i < 2*NPROC; i++) begin
            queue_valid[i] = 1'b0;
            queue_stamp[i] = '0;
        end
        for (int i = 0; i < NPROC; i++) begin
            ack_heard[i]       = 1'b0;
            ack_heard_stamp[i] = '0;
        end
        for (int i = 0; i < 8; i++)
            kind_seen[i] = 0;
        msgs_sent       = 0;
        results_checked = 0;
        mismatches      = 0;
        eq_grants       = 0;
        lab_grants      = 0;
        full_acks       = 0;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;

        in_if.valid    = 1'b0;
        in_if.kind     = '0;
        in_if.resource = 1'b0;
        in_if.sender   = '0;
        in_if.stamp    = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = '0;
        cfg_if.data    = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_reset_config();
        test_directed_register_extremes();
        test_random_phases();

        repeat (LATENCY + 6) @(posedge i_clk);
        if (outcome_q.size() != 0) begin
            $display("%0d results never arrived", outcome_q.size());
            mismatches += outcome_q.size();
        end

        $display("%0d messages (%0d of undefined kind) through %0d result beats, %0d cycles",
                 msgs_sent, kind_seen[5] + kind_seen[6] + kind_seen[7], results_checked,
                 cycle_count);
        $display("equipment held in %0d results, lab in %0d, full ack set in %0d",
                 eq_grants, lab_grants, full_acks);
        if (mismatches == 0) begin
            $display("lamport_request_queue: match");
        end else begin
            $display("lamport_request_queue: mismatch");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/lrq_pkg.sv
sv/lrq_if.sv
sv/lrq_table.sv
sv/lrq_grant.sv
sv/lrq_acks.sv
sv/lamport_request_queue.sv
sv/lrq_checker.sv
dv/tb_lamport_request_queue.sv
